FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, also checked through reset.
`define ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, sizes and codes for the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int PAGE_BITS   = 10;
   localparam int TOP_ORDER   = 9;
   localparam int QUEUE_DEPTH = 512;
   localparam int NUM_LISTS   = TOP_ORDER + 1;
   localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
   localparam int ORD_BITS    = 4;
   localparam int LIST_BITS   = $clog2(NUM_LISTS);
   localparam int ADDR_BITS   = LIST_BITS + QIDX_BITS;
   localparam int MEM_DEPTH   = NUM_LISTS * QUEUE_DEPTH;
   localparam int CNT_BITS    = QIDX_BITS + 1;
   localparam int FREE_BITS   = PAGE_BITS + 1;
   localparam int ACC_BITS    = CNT_BITS + TOP_ORDER;
   localparam int CHUNK_BITS  = PAGE_BITS - TOP_ORDER + 1;
   localparam int TPL_BITS    = 4;

   localparam logic [FREE_BITS-1:0] FREE_MAX  = FREE_BITS'(1) << PAGE_BITS;
   localparam logic [TPL_BITS-1:0]  TPL_RESET = TPL_BITS'(10);

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_ORDER = 2'd1;
   localparam logic [1:0] STATUS_NO_MEM    = 2'd2;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;

   typedef struct packed {
      logic                 we;
      logic [ADDR_BITS-1:0] waddr;
      logic [PAGE_BITS-1:0] wdata;
      logic [ADDR_BITS-1:0] raddr;
   } ram_req_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_SEARCH,
      ST_A_POP,
      ST_A_SPLIT,
      ST_A_PUSH,
      ST_F_CHECK,
      ST_F_SCAN,
      ST_F_PUSH,
      ST_Q_SUM
   } state_type;

endpackage
`default_nettype wire

FILE: sv/bpa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram
// Free list storage: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpa_ram (
   input  wire logic                                clock,
   input  wire bpa_pkg::ram_req_type                ram_req,
   output logic [bpa_pkg::PAGE_BITS-1:0]            ram_rdata
);
   import bpa_pkg::*;

   logic [PAGE_BITS-1:0] mem [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      ram_rdata <= mem[ram_req.raddr];
   end

endmodule
`default_nettype wire

FILE: sv/bpa_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_engine
// Sequencer and list bookkeeping for allocate, free and query.
// ----------------------------------------------------------------------------
module bpa_engine (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_func,
   input  wire logic [bpa_pkg::ORD_BITS-1:0]        req_order,
   input  wire logic [bpa_pkg::PAGE_BITS-1:0]       req_page_in,
   input  wire logic                                csr_we,
   input  wire logic [bpa_pkg::TPL_BITS-1:0]        csr_wdata,
   output logic                                     rsp_valid,
   output logic [1:0]                               rsp_status,
   output logic [bpa_pkg::PAGE_BITS-1:0]            rsp_page_out,
   output logic [bpa_pkg::FREE_BITS-1:0]            rsp_free_pages_total,
   output logic [bpa_pkg::FREE_BITS-1:0]            rsp_unusable_pages,
   output bpa_pkg::ram_req_type                     ram_req,
   input  wire logic [bpa_pkg::PAGE_BITS-1:0]       ram_rdata
);
   import bpa_pkg::*;

   state_type state_ff, state_in;
   logic [ORD_BITS-1:0]   k_ff, k_in, ord_ff, ord_in;
   logic [PAGE_BITS-1:0]  chunk_ff, chunk_in;
   logic [QIDX_BITS-1:0]  head_ff [NUM_LISTS];
   logic [QIDX_BITS-1:0]  head_in [NUM_LISTS];
   logic [CNT_BITS-1:0]   count_ff [NUM_LISTS];
   logic [CNT_BITS-1:0]   count_in [NUM_LISTS];
   logic [FREE_BITS-1:0]  free_ff, free_in;
   logic [TPL_BITS-1:0]   tpl_ff, tpl_in;
   logic [CNT_BITS-1:0]   rd_ff, rd_in, wr_ff, wr_in, scan_n_ff, scan_n_in;
   logic                  pend_ff, pend_in, found_ff, found_in;
   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [CHUNK_BITS-1:0] init_ff, init_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [PAGE_BITS-1:0]  rsp_page_ff, rsp_page_in;
   logic [FREE_BITS-1:0]  rsp_free_ff, rsp_free_in;
   logic [FREE_BITS-1:0]  rsp_unus_ff, rsp_unus_in;

   logic [CNT_BITS-1:0]   cur_cnt;
   logic [QIDX_BITS-1:0]  cur_head;
   logic [ORD_BITS-1:0]   tpl_clamp;
   logic [CHUNK_BITS-1:0] chunks;
   logic [FREE_BITS-1:0]  ord_size;
   logic [FREE_BITS:0]    free_sum;
   logic [PAGE_BITS-1:0]  buddy;
   logic [PAGE_BITS-1:0]  push_val;
   logic                  push_en;

   assign cur_cnt   = count_ff[k_ff];
   assign cur_head  = head_ff[k_ff];
   assign tpl_clamp = (tpl_ff < ORD_BITS'(TOP_ORDER)) ? ORD_BITS'(TOP_ORDER) :
                      (tpl_ff > ORD_BITS'(PAGE_BITS)) ? ORD_BITS'(PAGE_BITS) : tpl_ff;
   assign chunks    = CHUNK_BITS'(1) << (tpl_clamp - ORD_BITS'(TOP_ORDER));
   assign ord_size  = FREE_BITS'(1) << ord_ff;
   assign free_sum  = {1'b0, free_ff} + {1'b0, ord_size};
   assign buddy     = chunk_ff ^ (PAGE_BITS'(1) << k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         tpl_ff       <= TPL_RESET;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tpl_ff       <= tpl_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
      end
      k_ff          <= k_in;
      ord_ff        <= ord_in;
      chunk_ff      <= chunk_in;
      free_ff       <= free_in;
      rd_ff         <= rd_in;
      wr_ff         <= wr_in;
      scan_n_ff     <= scan_n_in;
      found_ff      <= found_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_unus_ff   <= rsp_unus_in;
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      ord_in        = ord_ff;
      chunk_in      = chunk_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      tpl_in        = tpl_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      scan_n_in     = scan_n_ff;
      pend_in       = 1'b0;
      found_in      = found_ff;
      acc_in        = acc_ff;
      init_in       = init_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_unus_in   = rsp_unus_ff;
      push_en       = 1'b0;
      push_val      = chunk_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = {LIST_BITS'(k_ff), cur_head + cur_cnt[QIDX_BITS-1:0]};
      ram_req.wdata = chunk_ff;
      ram_req.raddr = {LIST_BITS'(k_ff), cur_head};

      case (state_ff)
         ST_INIT: begin
            ram_req.we    = 1'b1;
            ram_req.waddr = {LIST_BITS'(TOP_ORDER), QIDX_BITS'(init_ff)};
            ram_req.wdata = PAGE_BITS'(init_ff) << TOP_ORDER;
            init_in       = init_ff + CHUNK_BITS'(1);
            if (init_ff == chunks - CHUNK_BITS'(1)) begin
               count_in[TOP_ORDER] = CNT_BITS'(chunks);
               free_in             = FREE_BITS'(1) << tpl_clamp;
               state_in            = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ord_in        = req_order;
               k_in          = req_order;
               chunk_in      = req_page_in & ({PAGE_BITS{1'b1}} << req_order);
               acc_in        = '0;
               rsp_page_in   = '0;
               rsp_unus_in   = '0;
               rsp_free_in   = free_ff;
               rsp_status_in = STATUS_OK;
               if (req_func != FUNC_NOP && req_order > ORD_BITS'(TOP_ORDER)) begin
                  rsp_status_in = STATUS_BAD_ORDER;
                  rsp_valid_in  = 1'b1;
               end else begin
                  case (req_func)
                     FUNC_ALLOC: state_in = ST_A_SEARCH;
                     FUNC_FREE:  state_in = ST_F_CHECK;
                     FUNC_QUERY: begin
                        k_in     = '0;
                        state_in = ST_Q_SUM;
                     end
                     default:    rsp_valid_in = 1'b1;
                  endcase
               end
            end
         end
         // walk up the orders until a list holds a chunk; read of its head is in flight
         ST_A_SEARCH: begin
            if (cur_cnt != '0) begin
               state_in = ST_A_POP;
            end else if (k_ff == ORD_BITS'(TOP_ORDER)) begin
               rsp_status_in = STATUS_NO_MEM;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               k_in = k_ff + ORD_BITS'(1);
            end
         end
         ST_A_POP: begin
            chunk_in       = ram_rdata;
            head_in[k_ff]  = cur_head + QIDX_BITS'(1);
            count_in[k_ff] = cur_cnt - CNT_BITS'(1);
            state_in       = ST_A_SPLIT;
         end
         ST_A_SPLIT: begin
            if (k_ff == ord_ff) begin
               free_in       = (free_ff > ord_size) ? free_ff - ord_size : '0;
               rsp_free_in   = (free_ff > ord_size) ? free_ff - ord_size : '0;
               rsp_page_in   = chunk_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               k_in     = k_ff - ORD_BITS'(1);
               state_in = ST_A_PUSH;
            end
         end
         ST_A_PUSH: begin
            push_en  = 1'b1;
            push_val = chunk_ff + (PAGE_BITS'(1) << k_ff);
            state_in = ST_A_SPLIT;
         end
         ST_F_CHECK: begin
            if (k_ff < ORD_BITS'(TOP_ORDER)) begin
               scan_n_in = cur_cnt;
               rd_in     = '0;
               wr_in     = '0;
               found_in  = 1'b0;
               state_in  = ST_F_SCAN;
            end else begin
               state_in = ST_F_PUSH;
            end
         end
         // stream the list: read ahead, compact the survivors behind the read pointer
         ST_F_SCAN: begin
            ram_req.raddr = {LIST_BITS'(k_ff), cur_head + rd_ff[QIDX_BITS-1:0]};
            if (rd_ff != scan_n_ff) begin
               rd_in   = rd_ff + CNT_BITS'(1);
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (ram_rdata == buddy) begin
                  found_in = 1'b1;
               end else begin
                  ram_req.we    = 1'b1;
                  ram_req.waddr = {LIST_BITS'(k_ff), cur_head + wr_ff[QIDX_BITS-1:0]};
                  ram_req.wdata = ram_rdata;
                  wr_in         = wr_ff + CNT_BITS'(1);
               end
            end
            if (rd_ff == scan_n_ff && !pend_ff) begin
               count_in[k_ff] = wr_ff;
               if (found_ff) begin
                  chunk_in = chunk_ff & ~(PAGE_BITS'(1) << k_ff);
                  k_in     = k_ff + ORD_BITS'(1);
                  state_in = ST_F_CHECK;
               end else begin
                  state_in = ST_F_PUSH;
               end
            end
         end
         ST_F_PUSH: begin
            push_en      = 1'b1;
            free_in      = (free_sum > {1'b0, FREE_MAX}) ? FREE_MAX : free_sum[FREE_BITS-1:0];
            rsp_free_in  = (free_sum > {1'b0, FREE_MAX}) ? FREE_MAX : free_sum[FREE_BITS-1:0];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_Q_SUM: begin
            if (k_ff < ord_ff) begin
               acc_in = acc_ff + (ACC_BITS'(cur_cnt) << k_ff);
               k_in   = k_ff + ORD_BITS'(1);
            end else begin
               rsp_unus_in  = (acc_ff > ACC_BITS'(FREE_MAX)) ? FREE_MAX :
                              acc_ff[FREE_BITS-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // tail push onto list k; drop when full
      if (push_en && cur_cnt < CNT_BITS'(QUEUE_DEPTH)) begin
         ram_req.we     = 1'b1;
         ram_req.wdata  = push_val;
         count_in[k_ff] = cur_cnt + CNT_BITS'(1);
      end

      if (csr_we) begin
         tpl_in   = csr_wdata;
         init_in  = '0;
         state_in = ST_INIT;
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_in[i]  = '0;
            count_in[i] = '0;
         end
      end
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_page_out         = rsp_page_ff;
   assign rsp_free_pages_total = rsp_free_ff;
   assign rsp_unusable_pages   = rsp_unus_ff;

endmodule
`default_nettype wire

FILE: sv/buddy_page_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Buddy page allocator with one FIFO free list per order.
// ----------------------------------------------------------------------------
// Allocate: search up the orders, pop the head, then split and push per order
//   split; query: sum the lists below the requested order. Free: scan the list
//   of each order, one list entry per cycle through the RAM, merging upward
//   while a buddy is found, then push the chunk; no scan at the top order.
// Result strobe is one cycle wide, the cycle after the last step; no stall.
// Reset and a csr write rebuild the lists with busy high.
module buddy_page_allocator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_func,
   input  wire logic [bpa_pkg::ORD_BITS-1:0]        req_order,
   input  wire logic [bpa_pkg::PAGE_BITS-1:0]       req_page_in,
   input  wire logic                                csr_we,
   input  wire logic [bpa_pkg::TPL_BITS-1:0]        csr_wdata,
   output logic                                     rsp_valid,
   output logic [1:0]                               rsp_status,
   output logic [bpa_pkg::PAGE_BITS-1:0]            rsp_page_out,
   output logic [bpa_pkg::FREE_BITS-1:0]            rsp_free_pages_total,
   output logic [bpa_pkg::FREE_BITS-1:0]            rsp_unusable_pages
);
   import bpa_pkg::*;

   ram_req_type          ram_req;
   logic [PAGE_BITS-1:0] ram_rdata;

   bpa_engine u_engine (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_func             (req_func),
      .req_order            (req_order),
      .req_page_in          (req_page_in),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_page_out         (rsp_page_out),
      .rsp_free_pages_total (rsp_free_pages_total),
      .rsp_unusable_pages   (rsp_unusable_pages),
      .ram_req              (ram_req),
      .ram_rdata            (ram_rdata)
   );

   bpa_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

endmodule
`default_nettype wire

FILE: sv/bpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpa_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic                                rsp_valid,
   input  wire logic [1:0]                          rsp_status,
   input  wire logic [bpa_pkg::PAGE_BITS-1:0]       rsp_page_out,
   input  wire logic [bpa_pkg::FREE_BITS-1:0]       rsp_free_pages_total,
   input  wire logic [bpa_pkg::FREE_BITS-1:0]       rsp_unusable_pages
);
   import bpa_pkg::*;

   // lists are rebuilt after reset before any word is taken
   `ASSERT_NEXT(a_init_after_reset, clock, reset, busy)
   `ASSERT_IMPLIES(a_fail_no_page, clock, reset,
      rsp_valid && rsp_status != STATUS_OK, rsp_page_out == '0)
   `ASSERT_IMPLIES(a_free_bound, clock, reset,
      rsp_valid, rsp_free_pages_total <= FREE_MAX)
   `ASSERT_IMPLIES(a_bad_order_unusable, clock, reset,
      rsp_valid && rsp_status == STATUS_BAD_ORDER, rsp_unusable_pages == '0)
   `ASSERT_IMPLIES(a_word_has_cause, clock, reset,
      rsp_valid, $past(busy) || $past(start))

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (.*);
`default_nettype wire
